// ===== rtl/core/owbm_pkg.sv =====
// Package for the one-wire bus master core: command codes, register
// indexes, register reset values and field widths.
// No dependencies.
package owbm_pkg;

   // Widths of the transfer fields and of the configuration registers
   localparam int FuncWidth = 3;
   localparam int DataWidth = 8;
   localparam int CsrWidth  = 10;
   localparam int CsrIndexWidth = 3;

   // Command codes carried in func
   typedef enum logic [FuncWidth-1:0] {
      FUNC_NONE  = 3'd0,
      FUNC_RESET = 3'd1,
      FUNC_WRITE = 3'd2,
      FUNC_RBYTE = 3'd3,
      FUNC_RBIT  = 3'd4
   } func_type;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRESENCE_WAIT = 3'd1,
      CSR_RESET_RECOVER = 3'd2,
      CSR_SLOT_GAP      = 3'd3,
      CSR_WRITE_LOW     = 3'd4,
      CSR_READ_LOW      = 3'd5,
      CSR_SAMPLE_DELAY  = 3'd6,
      CSR_SLOT_TAIL     = 3'd7
   } csr_index_type;

   // Register values after reset, in microseconds
   localparam logic [CsrWidth-1:0] ResetLowDefault     = 10'd500;
   localparam logic [CsrWidth-1:0] PresenceWaitDefault = 10'd60;
   localparam logic [CsrWidth-1:0] ResetRecoverDefault = 10'd420;
   localparam logic [CsrWidth-1:0] SlotGapDefault      = 10'd2;
   localparam logic [CsrWidth-1:0] WriteLowDefault     = 10'd10;
   localparam logic [CsrWidth-1:0] ReadLowDefault      = 10'd2;
   localparam logic [CsrWidth-1:0] SampleDelayDefault  = 10'd2;
   localparam logic [CsrWidth-1:0] SlotTailDefault     = 10'd90;

endpackage

// ===== rtl/core/owbm_if.sv =====
// Channel interfaces of the one-wire bus master core: the tick request
// channel and the tick result channel, valid/ready handshake.
// Depends on owbm_pkg.
interface owbm_req_if;
   logic                             valid;
   logic                             ready;
   logic [owbm_pkg::FuncWidth-1:0]   func;
   logic [owbm_pkg::DataWidth-1:0]   write_data;
   logic                             line_level;

   modport source (output valid, output func, output write_data, output line_level,
                   input ready);
   modport sink   (input valid, input func, input write_data, input line_level,
                   output ready);
endinterface

interface owbm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             drive_low;
   logic                             busy_res;
   logic                             done_res;
   logic [owbm_pkg::DataWidth-1:0]   read_data;
   logic                             presence;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output read_data, output presence, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input read_data, input presence, output ready);
endinterface

// ===== rtl/core/one_wire_bus_master_core.sv =====
// One-wire bus master core: sequencer, slot timer and configuration registers.
// Depends on owbm_pkg and the channel interfaces in owbm_if.sv.
//
// Usage: every transfer on req_chan is one microsecond of bus time. It carries
// the sampled line level and, while the master is idle, may start a command
// (bus reset with presence detect, byte write, byte read, bit read). For each
// request the core returns one result on rsp_chan: the drive_low level for the
// open-drain pad, busy and done flags, the last byte read and the presence flag.
// The result of a request sits in the result register from the cycle after its
// transfer. Throughput is one request per cycle unless rsp_chan stalls; the
// single pass through the sequencer logic between the state registers and the
// result register sets that figure. When rsp_chan stalls, the result register
// holds and req_chan.ready drops until the result is taken, so no tick is lost.
// Reset (synchronous, active high) returns the sequencer to idle, clears read
// data and presence, and loads the timing registers with their defaults. Write
// timing registers via csr_we/csr_index/csr_wdata only while idle, unchecked by
// the core. Durations longer than the timer saturate to 2^TIMER_WIDTH - 1 ticks.
module one_wire_bus_master_core #(
   parameter int TIMER_WIDTH = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   owbm_req_if.sink                              req_chan,
   owbm_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [owbm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [owbm_pkg::CsrWidth-1:0]         csr_wdata
);

   localparam int CmpWidth = (TIMER_WIDTH > owbm_pkg::CsrWidth) ? TIMER_WIDTH
                                                                 : owbm_pkg::CsrWidth;
   localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;
   localparam logic [TIMER_WIDTH-1:0] TimerOne = TIMER_WIDTH'(1);

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_R_LOW     = 4'd1,
      PH_R_WAIT    = 4'd2,
      PH_R_SAMPLE  = 4'd3,
      PH_R_RISE    = 4'd4,
      PH_R_REC     = 4'd5,
      PH_GAP       = 4'd6,
      PH_W_LOW     = 4'd7,
      PH_W_TAIL    = 4'd8,
      PH_RD_LOW    = 4'd9,
      PH_RD_DELAY  = 4'd10,
      PH_RD_SAMPLE = 4'd11,
      PH_RD_TAIL   = 4'd12
   } phase_type;

   typedef struct packed {
      logic [TIMER_WIDTH-1:0] r_low;
      logic [TIMER_WIDTH-1:0] r_wait;
      logic [TIMER_WIDTH-1:0] r_rec;
      logic [TIMER_WIDTH-1:0] gap;
      logic [TIMER_WIDTH-1:0] w_low;
      logic [TIMER_WIDTH-1:0] rd_low;
      logic [TIMER_WIDTH-1:0] rd_delay;
      logic [TIMER_WIDTH-1:0] tail;
   } dur_type;

   typedef struct packed {
      phase_type              ph;
      logic [TIMER_WIDTH-1:0] tl;
      logic                   fin;
   } go_type;

   // Saturate a register value to the timer range
   function automatic logic [TIMER_WIDTH-1:0] sat_timer(
      input logic [owbm_pkg::CsrWidth-1:0] v);
      logic [CmpWidth-1:0] ext;
      begin
         ext = CmpWidth'(v);
         if (ext > CmpWidth'(TimerMax)) begin
            sat_timer = TimerMax;
         end else begin
            sat_timer = TIMER_WIDTH'(ext);
         end
      end
   endfunction

   // Treat zero as one for minimum-one registers
   function automatic logic [owbm_pkg::CsrWidth-1:0] min_one(
      input logic [owbm_pkg::CsrWidth-1:0] v);
      min_one = (v == '0) ? owbm_pkg::CsrWidth'(1) : v;
   endfunction

   // Length of a timed phase
   function automatic logic [TIMER_WIDTH-1:0] dur_of(input phase_type p,
                                                       input dur_type d);
      case (p)
         PH_R_LOW:    dur_of = d.r_low;
         PH_R_WAIT:   dur_of = d.r_wait;
         PH_R_REC:    dur_of = d.r_rec;
         PH_GAP:      dur_of = d.gap;
         PH_W_LOW:    dur_of = d.w_low;
         PH_RD_LOW:   dur_of = d.rd_low;
         PH_RD_DELAY: dur_of = d.rd_delay;
         PH_W_TAIL,
         PH_RD_TAIL:  dur_of = d.tail;
         default:     dur_of = TimerOne;
      endcase
   endfunction

   // Enter a phase, skipping parts of zero length
   function automatic go_type go_fn(input phase_type p, input logic is_write,
                                    input dur_type d);
      phase_type q;
      go_type    r;
      begin
         q = p;
         if (q == PH_GAP && d.gap == '0) begin
            q = is_write ? PH_W_LOW : PH_RD_LOW;
         end
         if (q == PH_RD_DELAY && d.rd_delay == '0) begin
            q = PH_RD_SAMPLE;
         end
         r.ph  = q;
         r.tl  = dur_of(q, d);
         r.fin = (q == PH_R_REC) && (d.r_rec == '0);
         go_fn = r;
      end
   endfunction

   // Configuration registers
   logic [owbm_pkg::CsrWidth-1:0] csr_ff [8];

   // Sequencer state
   phase_type                       phase_ff,   phase_in;
   logic [owbm_pkg::FuncWidth-1:0]  op_ff,      op_in;
   logic [TIMER_WIDTH-1:0]          time_ff,    time_in;
   logic [2:0]                      bit_ff,     bit_in;
   logic [owbm_pkg::DataWidth-1:0]  shift_ff,   shift_in;
   logic [owbm_pkg::DataWidth-1:0]  rbyte_ff,   rbyte_in;
   logic                            pres_ff,    pres_in;

   // Result register
   logic                            rsp_valid_ff;
   logic                            drive_ff,   drive_in;
   logic                            busy_ff;
   logic                            done_ff,    done_in;

   dur_type  dur;
   go_type   g;
   logic     fin;
   logic     req_xfer;
   logic     is_write;
   phase_type p;

   // Effective durations
   always_comb begin
      dur.r_low    = sat_timer(min_one(csr_ff[owbm_pkg::CSR_RESET_LOW]));
      dur.r_wait   = sat_timer(min_one(csr_ff[owbm_pkg::CSR_PRESENCE_WAIT]));
      dur.r_rec    = sat_timer(csr_ff[owbm_pkg::CSR_RESET_RECOVER]);
      dur.gap      = sat_timer(csr_ff[owbm_pkg::CSR_SLOT_GAP]);
      dur.w_low    = sat_timer(min_one(csr_ff[owbm_pkg::CSR_WRITE_LOW]));
      dur.rd_low   = sat_timer(min_one(csr_ff[owbm_pkg::CSR_READ_LOW]));
      dur.rd_delay = sat_timer(csr_ff[owbm_pkg::CSR_SAMPLE_DELAY]);
      dur.tail     = sat_timer(min_one(csr_ff[owbm_pkg::CSR_SLOT_TAIL]));
   end

   // Accept a tick whenever the result register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // One tick of the sequencer
   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      time_in  = time_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      rbyte_in = rbyte_ff;
      pres_in  = pres_ff;
      drive_in = 1'b0;
      fin      = 1'b0;
      g        = '0;
      p        = PH_IDLE;

      // Start a command when idle
      if (phase_ff == PH_IDLE && req_chan.func >= owbm_pkg::FUNC_RESET &&
          req_chan.func <= owbm_pkg::FUNC_RBIT) begin
         op_in    = req_chan.func;
         bit_in   = '0;
         shift_in = (req_chan.func == owbm_pkg::FUNC_WRITE) ? req_chan.write_data : '0;
         g = go_fn((req_chan.func == owbm_pkg::FUNC_RESET) ? PH_R_LOW : PH_GAP,
                   (req_chan.func == owbm_pkg::FUNC_WRITE), dur);
         phase_in = g.ph;
         time_in  = g.tl;
      end

      is_write = (op_in == owbm_pkg::FUNC_WRITE);

      if (phase_in != PH_IDLE) begin
         p = phase_in;
         if (p == PH_R_LOW || p == PH_W_LOW || p == PH_RD_LOW) begin
            drive_in = 1'b1;
         end else if (p == PH_W_TAIL && !shift_in[0]) begin
            drive_in = 1'b1;
         end

         unique case (p)
            PH_R_SAMPLE: begin
               if (!req_chan.line_level) begin
                  pres_in  = 1'b1;
                  phase_in = PH_R_RISE;
               end else begin
                  pres_in = 1'b0;
                  fin     = 1'b1;
               end
            end
            PH_R_RISE: begin
               if (req_chan.line_level) begin
                  if (dur.r_rec <= TimerOne) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = PH_R_REC;
                     time_in  = dur.r_rec - TimerOne;
                  end
               end
            end
            PH_RD_SAMPLE: begin
               shift_in[bit_ff] = shift_in[bit_ff] | req_chan.line_level;
               g        = go_fn(PH_RD_TAIL, is_write, dur);
               phase_in = g.ph;
               time_in  = g.tl;
            end
            PH_R_LOW, PH_R_WAIT, PH_R_REC, PH_GAP, PH_W_LOW, PH_W_TAIL,
            PH_RD_LOW, PH_RD_DELAY, PH_RD_TAIL: begin
               if (time_in <= TimerOne) begin
                  // Timed phase expires: advance
                  unique case (p)
                     PH_R_LOW:    g = go_fn(PH_R_WAIT, is_write, dur);
                     PH_R_WAIT:   g = go_fn(PH_R_SAMPLE, is_write, dur);
                     PH_GAP:      g = go_fn(is_write ? PH_W_LOW : PH_RD_LOW,
                                            is_write, dur);
                     PH_W_LOW:    g = go_fn(PH_W_TAIL, is_write, dur);
                     PH_RD_LOW:   g = go_fn(PH_RD_DELAY, is_write, dur);
                     PH_RD_DELAY: g = go_fn(PH_RD_SAMPLE, is_write, dur);
                     default:     g = go_fn(PH_GAP, is_write, dur);
                  endcase
                  if (p == PH_R_REC) begin
                     fin = 1'b1;
                  end else if (p == PH_W_TAIL || p == PH_RD_TAIL) begin
                     // End of a bit slot
                     bit_in = bit_ff + 3'd1;
                     if (is_write) begin
                        shift_in = shift_in >> 1;
                     end
                     if (op_in == owbm_pkg::FUNC_RBIT || bit_in == 3'd0) begin
                        fin = 1'b1;
                     end else begin
                        phase_in = g.ph;
                        time_in  = g.tl;
                        fin      = g.fin;
                     end
                  end else begin
                     phase_in = g.ph;
                     time_in  = g.tl;
                     fin      = g.fin;
                  end
               end else begin
                  time_in = time_in - TimerOne;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               time_in  = '0;
            end
         endcase
      end

      // Finish the command: latch read data and drop to idle
      if (fin) begin
         if (op_in == owbm_pkg::FUNC_RBYTE || op_in == owbm_pkg::FUNC_RBIT) begin
            rbyte_in = shift_in;
         end
         phase_in = PH_IDLE;
         time_in  = '0;
      end
      done_in = fin;
   end

   // Hold configuration; write on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[owbm_pkg::CSR_RESET_LOW]     <= owbm_pkg::ResetLowDefault;
         csr_ff[owbm_pkg::CSR_PRESENCE_WAIT] <= owbm_pkg::PresenceWaitDefault;
         csr_ff[owbm_pkg::CSR_RESET_RECOVER] <= owbm_pkg::ResetRecoverDefault;
         csr_ff[owbm_pkg::CSR_SLOT_GAP]      <= owbm_pkg::SlotGapDefault;
         csr_ff[owbm_pkg::CSR_WRITE_LOW]     <= owbm_pkg::WriteLowDefault;
         csr_ff[owbm_pkg::CSR_READ_LOW]      <= owbm_pkg::ReadLowDefault;
         csr_ff[owbm_pkg::CSR_SAMPLE_DELAY]  <= owbm_pkg::SampleDelayDefault;
         csr_ff[owbm_pkg::CSR_SLOT_TAIL]     <= owbm_pkg::SlotTailDefault;
      end else if (csr_we) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   // Advance sequencer state on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= '0;
         time_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         rbyte_ff <= '0;
         pres_ff  <= '0;
      end else if (req_xfer) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         time_ff  <= time_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rbyte_ff <= rbyte_in;
         pres_ff  <= pres_in;
      end
   end

   // Load the result register on a request transfer, drop it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         drive_ff <= drive_in;
         busy_ff  <= (phase_in != PH_IDLE);
         done_ff  <= done_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive_low = drive_ff;
   assign rsp_chan.busy_res  = busy_ff;
   assign rsp_chan.done_res  = done_ff;
   assign rsp_chan.read_data = rbyte_ff;
   assign rsp_chan.presence  = pres_ff;

endmodule

// ===== sim/tb_one_wire_bus_master_core.sv =====
// Self-checking testbench for one_wire_bus_master_core: tick requests in, one result per tick out,
// compared against a cycle-level model of the sequencer kept in this file.
// Depends on owbm_pkg and the channel interfaces in owbm_if.sv.
module tb_one_wire_bus_master_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FuncWidth  = owbm_pkg::FuncWidth;
   localparam int DataWidth  = owbm_pkg::DataWidth;
   localparam int CsrWidth   = owbm_pkg::CsrWidth;
   localparam int TimerWidth = 10;
   localparam int TimerMax   = (1 << TimerWidth) - 1;

   // Sequencer phases of the bus model
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_SAMPLE, SEQ_RST_RISE, SEQ_RST_RECOVER,
      SEQ_GAP, SEQ_WR_LOW, SEQ_WR_TAIL, SEQ_RD_LOW, SEQ_RD_DELAY, SEQ_RD_SAMPLE, SEQ_RD_TAIL
   } seq_phase_type;

   typedef enum logic [1:0] {ACT_TICK, ACT_DRAIN, ACT_SETTLE, ACT_CSR} act_kind_type;

   typedef enum logic [1:0] {
      TIMING_DIRECTED, TIMING_ZERO, TIMING_SHORT
   } timing_mode_type;

   typedef struct packed {
      logic [FuncWidth-1:0] func;
      logic [DataWidth-1:0] wdata;
      logic                 line;
   } tick_type;

   typedef struct packed {
      logic                 drive_low;
      logic                 busy;
      logic                 done;
      logic [DataWidth-1:0] read_data;
      logic                 presence;
   } tick_result_type;

   typedef struct {
      act_kind_type            kind;
      tick_type                tick;
      owbm_pkg::csr_index_type idx;
      logic [CsrWidth-1:0]     value;
   } action_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Block inputs, all known from time zero
   logic                    tx_valid = 1'b0;
   logic [FuncWidth-1:0]    tx_func = owbm_pkg::FUNC_NONE;
   logic [DataWidth-1:0]    tx_wdata = '0;
   logic                    tx_line = 1'b1;
   logic                    rx_ready = 1'b0;
   logic                    csr_we = 1'b0;
   owbm_pkg::csr_index_type csr_index = owbm_pkg::CSR_RESET_LOW;
   logic [CsrWidth-1:0]     csr_wdata = '0;

   owbm_req_if req_chan ();
   owbm_rsp_if rsp_chan ();

   assign req_chan.valid      = tx_valid;
   assign req_chan.func       = tx_func;
   assign req_chan.write_data = tx_wdata;
   assign req_chan.line_level = tx_line;
   assign rsp_chan.ready      = rx_ready;

   one_wire_bus_master_core #(.TIMER_WIDTH(TimerWidth)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state and the mirrored timing registers
   logic [CsrWidth-1:0]  timing_reg [8];
   seq_phase_type        m_phase;
   owbm_pkg::func_type   m_op;
   int                   m_left;
   logic [2:0]           m_bit;
   logic [DataWidth-1:0] m_shift;
   logic [DataWidth-1:0] m_rdata;
   logic                 m_presence;
   logic                 m_done;

   tick_result_type tick_results_q [$];
   action_type      plan_q [$];

   // Handshake bookkeeping
   logic     req_fire = 1'b0;
   logic     rsp_fire = 1'b0;
   logic     offering = 1'b0;
   tick_type cur_tick = '{owbm_pkg::FUNC_NONE, '0, 1'b1};
   int       tx_gap = 0;
   int       rx_stall = 0;
   int       hold_left = 0;
   bit       hold_done = 1'b0;

   // Run statistics
   int fail_count = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int resets_started = 0;
   int writes_started = 0;
   int rbytes_started = 0;
   int rbits_started = 0;
   int presence_hits = 0;

   function automatic logic [CsrWidth-1:0] timing_default(owbm_pkg::csr_index_type idx);
      case (idx)
         owbm_pkg::CSR_RESET_LOW:     return owbm_pkg::ResetLowDefault;
         owbm_pkg::CSR_PRESENCE_WAIT: return owbm_pkg::PresenceWaitDefault;
         owbm_pkg::CSR_RESET_RECOVER: return owbm_pkg::ResetRecoverDefault;
         owbm_pkg::CSR_SLOT_GAP:      return owbm_pkg::SlotGapDefault;
         owbm_pkg::CSR_WRITE_LOW:     return owbm_pkg::WriteLowDefault;
         owbm_pkg::CSR_READ_LOW:      return owbm_pkg::ReadLowDefault;
         owbm_pkg::CSR_SAMPLE_DELAY:  return owbm_pkg::SampleDelayDefault;
         default:                     return owbm_pkg::SlotTailDefault;
      endcase
   endfunction

   function automatic int clip(int v);
      return (v > TimerMax) ? TimerMax : v;
   endfunction

   function automatic int at_least_one(int v);
      return (v == 0) ? 1 : v;
   endfunction

   // Length in ticks of a timed phase under the current register settings
   function automatic int phase_span(seq_phase_type p);
      case (p)
         SEQ_RST_LOW:
            return clip(at_least_one(timing_reg[owbm_pkg::CSR_RESET_LOW]));
         SEQ_RST_WAIT:
            return clip(at_least_one(timing_reg[owbm_pkg::CSR_PRESENCE_WAIT]));
         SEQ_RST_RECOVER:
            return clip(timing_reg[owbm_pkg::CSR_RESET_RECOVER]);
         SEQ_GAP:
            return clip(timing_reg[owbm_pkg::CSR_SLOT_GAP]);
         SEQ_WR_LOW:
            return clip(at_least_one(timing_reg[owbm_pkg::CSR_WRITE_LOW]));
         SEQ_RD_LOW:
            return clip(at_least_one(timing_reg[owbm_pkg::CSR_READ_LOW]));
         SEQ_RD_DELAY:
            return clip(timing_reg[owbm_pkg::CSR_SAMPLE_DELAY]);
         SEQ_WR_TAIL,
         SEQ_RD_TAIL:
            return clip(at_least_one(timing_reg[owbm_pkg::CSR_SLOT_TAIL]));
         default:
            return 1;
      endcase
   endfunction

   task automatic end_command();
      if (m_op == owbm_pkg::FUNC_RBYTE || m_op == owbm_pkg::FUNC_RBIT)
         m_rdata = m_shift;
      m_phase = SEQ_IDLE;
      m_left  = 0;
      m_done  = 1'b1;
   endtask

   // Move to phase p on the next tick, skipping zero-length parts
   task automatic enter_phase(input seq_phase_type p);
      seq_phase_type q;
      q = p;
      if (q == SEQ_GAP && phase_span(SEQ_GAP) == 0)
         q = (m_op == owbm_pkg::FUNC_WRITE) ? SEQ_WR_LOW : SEQ_RD_LOW;
      if (q == SEQ_RD_DELAY && phase_span(SEQ_RD_DELAY) == 0)
         q = SEQ_RD_SAMPLE;
      if (q == SEQ_RST_RECOVER && phase_span(SEQ_RST_RECOVER) == 0) begin
         end_command();
      end else begin
         m_phase = q;
         m_left  = phase_span(q);
      end
   endtask

   task automatic close_bit();
      m_bit = m_bit + 3'd1;
      if (m_op == owbm_pkg::FUNC_WRITE)
         m_shift = m_shift >> 1;
      if (m_op == owbm_pkg::FUNC_RBIT || m_bit == 3'd0)
         end_command();
      else
         enter_phase(SEQ_GAP);
   endtask

   task automatic expire_phase(input seq_phase_type p);
      case (p)
         SEQ_RST_LOW:     enter_phase(SEQ_RST_WAIT);
         SEQ_RST_WAIT:    enter_phase(SEQ_RST_SAMPLE);
         SEQ_RST_RECOVER: end_command();
         SEQ_GAP:         enter_phase((m_op == owbm_pkg::FUNC_WRITE) ? SEQ_WR_LOW : SEQ_RD_LOW);
         SEQ_WR_LOW:      enter_phase(SEQ_WR_TAIL);
         SEQ_RD_LOW:      enter_phase(SEQ_RD_DELAY);
         SEQ_RD_DELAY:    enter_phase(SEQ_RD_SAMPLE);
         default:         close_bit();
      endcase
   endtask

   // Advance the bus model by one microsecond tick and return its outputs
   task automatic advance_bus(input tick_type t, output tick_result_type r);
      logic          drive;
      int            rec;
      seq_phase_type p;
      drive  = 1'b0;
      m_done = 1'b0;
      if (m_phase == SEQ_IDLE && t.func >= owbm_pkg::FUNC_RESET &&
          t.func <= owbm_pkg::FUNC_RBIT) begin
         m_op    = owbm_pkg::func_type'(t.func);
         m_bit   = 3'd0;
         m_shift = (m_op == owbm_pkg::FUNC_WRITE) ? t.wdata : '0;
         case (m_op)
            owbm_pkg::FUNC_RESET: resets_started++;
            owbm_pkg::FUNC_WRITE: writes_started++;
            owbm_pkg::FUNC_RBYTE: rbytes_started++;
            default:              rbits_started++;
         endcase
         enter_phase((m_op == owbm_pkg::FUNC_RESET) ? SEQ_RST_LOW : SEQ_GAP);
      end
      if (m_phase != SEQ_IDLE) begin
         p = m_phase;
         if (p == SEQ_RST_LOW || p == SEQ_WR_LOW || p == SEQ_RD_LOW)
            drive = 1'b1;
         else if (p == SEQ_WR_TAIL && !m_shift[0])
            drive = 1'b1;
         case (p)
            SEQ_RST_SAMPLE: begin
               if (!t.line) begin
                  m_presence = 1'b1;
                  m_phase    = SEQ_RST_RISE;
                  presence_hits++;
               end else begin
                  m_presence = 1'b0;
                  end_command();
               end
            end
            SEQ_RST_RISE: begin
               if (t.line) begin
                  rec = phase_span(SEQ_RST_RECOVER);
                  if (rec <= 1) begin
                     end_command();
                  end else begin
                     m_phase = SEQ_RST_RECOVER;
                     m_left  = rec - 1;
                  end
               end
            end
            SEQ_RD_SAMPLE: begin
               m_shift = m_shift | (DataWidth'(t.line) << m_bit);
               enter_phase(SEQ_RD_TAIL);
            end
            default: begin
               if (m_left <= 1)
                  expire_phase(p);
               else
                  m_left--;
            end
         endcase
      end
      r = '{drive, (m_phase != SEQ_IDLE), m_done, m_rdata, m_presence};
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: check results against the model, then feed accepted ticks to it
   always @(posedge clock) begin
      tick_result_type want;
      tick_result_type pred;
      tick_type        acc;
      if (reset) begin
         for (int i = 0; i < 8; i++)
            timing_reg[i] = timing_default(owbm_pkg::csr_index_type'(i));
         m_phase    = SEQ_IDLE;
         m_op       = owbm_pkg::FUNC_NONE;
         m_left     = 0;
         m_bit      = 3'd0;
         m_shift    = '0;
         m_rdata    = '0;
         m_presence = 1'b0;
         m_done     = 1'b0;
         tick_results_q.delete();
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         rsp_fire <= rsp_chan.valid && rsp_chan.ready;
         if (csr_we) begin
            timing_reg[csr_index] = csr_wdata;
            csr_writes++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (tick_results_q.size() == 0) begin
               $error("result transfer with no tick outstanding");
               fail_count++;
            end else begin
               want = tick_results_q.pop_front();
               check_field("drive_low", 8'(want.drive_low), 8'(rsp_chan.drive_low));
               check_field("busy_res", 8'(want.busy), 8'(rsp_chan.busy_res));
               check_field("done_res", 8'(want.done), 8'(rsp_chan.done_res));
               check_field("read_data", want.read_data, rsp_chan.read_data);
               check_field("presence", 8'(want.presence), 8'(rsp_chan.presence));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            acc = '{req_chan.func, req_chan.write_data, req_chan.line_level};
            advance_bus(acc, pred);
            tick_results_q.push_back(pred);
         end
      end
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic tick_type idle_tick();
      return '{owbm_pkg::FUNC_NONE, DataWidth'($urandom), 1'($urandom_range(0, 1))};
   endfunction

   // Driver: offer ticks from the plan, run fillers and register writes between phases
   always @(negedge clock) begin
      action_type head;
      logic       we;
      we = 1'b0;
      if (!reset) begin
         if (offering && req_fire) begin
            offering = 1'b0;
            ticks_sent++;
            tx_gap = draw_wait((ticks_sent / 250) % 4 == 3);
         end
         if (!offering && tx_gap > 0) begin
            tx_gap--;
         end else if (!offering && plan_q.size() > 0) begin
            head = plan_q[0];
            case (head.kind)
               ACT_TICK: begin
                  cur_tick = head.tick;
                  offering = 1'b1;
                  plan_q.delete(0);
               end
               ACT_DRAIN: begin
                  if (m_phase != SEQ_IDLE) begin
                     cur_tick = idle_tick();
                     offering = 1'b1;
                  end else begin
                     plan_q.delete(0);
                  end
               end
               ACT_SETTLE: begin
                  if (tick_results_q.size() == 0)
                     plan_q.delete(0);
               end
               default: begin
                  // finish the command in flight, then wait for its results
                  if (m_phase != SEQ_IDLE) begin
                     cur_tick = idle_tick();
                     offering = 1'b1;
                  end else if (tick_results_q.size() == 0) begin
                     we = 1'b1;
                     csr_index <= head.idx;
                     csr_wdata <= head.value;
                     plan_q.delete(0);
                  end
               end
            endcase
         end
      end
      tx_valid <= offering;
      tx_func  <= cur_tick.func;
      tx_wdata <= cur_tick.wdata;
      tx_line  <= cur_tick.line;
      csr_we   <= we;
   end

   // Receiver: random stall per result, one long hold-off partway through
   always @(negedge clock) begin
      logic rdy;
      rdy = 1'b0;
      if (!reset) begin
         if (rsp_fire)
            rx_stall = draw_wait((results_seen / 200) % 4 == 1);
         if (!hold_done && results_seen >= 600) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0)
            hold_left--;
         else if (rx_stall > 0)
            rx_stall--;
         else
            rdy = 1'b1;
      end
      rx_ready <= rdy;
   end

   task automatic push_tick(input logic [FuncWidth-1:0] func, input logic [DataWidth-1:0] wdata,
                            input logic line);
      plan_q.push_back('{ACT_TICK, '{func, wdata, line}, owbm_pkg::CSR_RESET_LOW, '0});
   endtask

   task automatic push_kind(input act_kind_type kind);
      plan_q.push_back('{kind, '0, owbm_pkg::CSR_RESET_LOW, '0});
   endtask

   task automatic push_csr(input owbm_pkg::csr_index_type idx, input logic [CsrWidth-1:0] value);
      plan_q.push_back('{ACT_CSR, '0, idx, value});
   endtask

   function automatic logic [CsrWidth-1:0] short_span();
      if ($urandom_range(0, 6) == 0)
         return CsrWidth'($urandom_range(5, 40));
      return CsrWidth'($urandom_range(0, 4));
   endfunction

   task automatic plan_timing(input timing_mode_type mode);
      logic [CsrWidth-1:0]     v;
      owbm_pkg::csr_index_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = owbm_pkg::csr_index_type'(i);
         case (mode)
            TIMING_ZERO:  v = '0;
            TIMING_SHORT: v = short_span();
            default:      v = (idx == owbm_pkg::CSR_RESET_LOW) ? 10'd2 :
                              (idx == owbm_pkg::CSR_RESET_RECOVER) ? 10'd3 : 10'd1;
         endcase
         push_csr(idx, v);
      end
   endtask

   // Random ticks: mostly commands or none, any func code, random data and line
   task automatic plan_random(input int count);
      logic [FuncWidth-1:0] f;
      for (int i = 0; i < count; i++) begin
         f = ($urandom_range(0, 3) == 0) ? FuncWidth'(owbm_pkg::FUNC_NONE)
                                         : FuncWidth'($urandom_range(0, 7));
         push_tick(f, DataWidth'($urandom), 1'($urandom_range(0, 1)));
         if (i == count / 2)
            push_kind(ACT_SETTLE);
      end
      push_kind(ACT_DRAIN);
   endtask

   // Limit: far above the slowest legal run
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      // Timings left at their reset values: one bit read
      push_tick(owbm_pkg::FUNC_RBIT, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      // Directed timings: reset samples presence on its fourth tick
      plan_timing(TIMING_DIRECTED);
      push_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b0);
      repeat (3) push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b0);
      push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      // reset with no presence ends on the sample tick
      push_tick(owbm_pkg::FUNC_RESET, 8'hFF, 1'b1);
      repeat (3) push_tick(owbm_pkg::FUNC_NONE, 8'hFF, 1'b1);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_WRITE, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_WRITE, 8'hFF, 1'b0);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_RBYTE, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_RBIT, 8'h00, 1'b0);
      push_kind(ACT_DRAIN);
      // undefined codes do nothing while idle
      push_tick(3'd5, 8'h12, 1'b1);
      push_tick(3'd6, 8'h34, 1'b0);
      push_tick(3'd7, 8'h56, 1'b1);
      // a write starts; the commands offered while it is busy are ignored
      push_tick(owbm_pkg::FUNC_WRITE, 8'hA5, 1'b1);
      push_tick(owbm_pkg::FUNC_RBYTE, 8'h5A, 1'b1);
      push_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b0);
      push_kind(ACT_DRAIN);
      // zero recovery: reset ends on the tick the line rises
      push_csr(owbm_pkg::CSR_RESET_RECOVER, '0);
      push_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b0);
      repeat (3) push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b0);
      push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      // all registers zero: minimum-one parts act as one, the rest are skipped
      plan_timing(TIMING_ZERO);
      push_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b0);
      push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b0);
      push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b0);
      push_tick(owbm_pkg::FUNC_NONE, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_WRITE, 8'h5A, 1'b1);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_RBYTE, 8'h00, 1'b0);
      push_kind(ACT_DRAIN);
      push_tick(owbm_pkg::FUNC_RBIT, 8'h00, 1'b1);
      push_kind(ACT_DRAIN);
      // random phases under short timings
      repeat (4) begin
         plan_timing(TIMING_SHORT);
         plan_random(350);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain the plan, then every outstanding result
      while (plan_q.size() > 0 || offering)
         @(posedge clock);
      while (tick_results_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d ticks, %0d results, %0d register writes, %0d presence pulses.",
               ticks_sent, results_seen, csr_writes, presence_hits);
      $display("Commands started: %0d resets, %0d byte writes, %0d byte reads, %0d bit reads.",
               resets_started, writes_started, rbytes_started, rbits_started);
      if (fail_count == 0 && tick_results_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
